[rtl/mrfl_pkg.sv]
package mrfl_pkg;

    localparam int NUM_CLASSES        = 6;
    localparam int LABEL_W            = 3;
    localparam int INTENSITY_W        = 8;
    localparam int LIK_W              = 16;
    localparam int WEIGHT_W           = 16;
    localparam int INTENSITY_LEVELS_DEF = 256;

    // Q8.8 likelihood to Q.19 energy
    localparam int LIK_SHIFT          = 11;
    // per-class sum of six clique potentials: -6..12
    localparam int SUM_W              = 5;
    // 128 * face + 181 * edge: -2940..5880
    localparam int SCORE_W            = 14;
    localparam int PROD_W             = WEIGHT_W + 1 + SCORE_W;
    localparam int ENERGY_W           = 32;

    localparam logic signed [SCORE_W-1:0] SQRT2_Q7 = 14'sd181;

    localparam logic [WEIGHT_W-1:0] SMOOTHING_RESET = 16'd4096;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    // word address of the smoothing weight register
    localparam logic ADDR_SMOOTHING = 1'b0;

    localparam logic OP_CLASSIFY = 1'b0;
    localparam logic OP_LOAD     = 1'b1;

    // row = class, column = neighbor label
    localparam logic signed [2:0] CLIQUE_POT [NUM_CLASSES][8] = '{
        '{3'sd0,  3'sd2, -3'sd1, -3'sd1,  3'sd1, -3'sd1,  3'sd1, 3'sd0},
        '{3'sd0, -3'sd1,  3'sd2, -3'sd1,  3'sd1,  3'sd1, -3'sd1, 3'sd0},
        '{3'sd0, -3'sd1, -3'sd1,  3'sd2, -3'sd1,  3'sd1, -3'sd1, 3'sd0},
        '{3'sd0,  3'sd1,  3'sd1, -3'sd1,  3'sd2,  3'sd1,  3'sd1, 3'sd0},
        '{3'sd0, -3'sd1,  3'sd1,  3'sd1,  3'sd1,  3'sd2, -3'sd1, 3'sd0},
        '{3'sd0,  3'sd1, -3'sd1, -3'sd1,  3'sd1, -3'sd1,  3'sd2, 3'sd0}
    };

    typedef struct packed {
        logic                    operation;
        logic [INTENSITY_W-1:0]  intensity;
        logic [LABEL_W-1:0]      current_label;
        logic [6*LABEL_W-1:0]    face_labels;
        logic [12*LABEL_W-1:0]   edge_labels;
        logic [LABEL_W-1:0]      class_index;
        logic signed [LIK_W-1:0] likelihood_value;
    } voxel_t;

    typedef struct packed {
        logic [LABEL_W-1:0] new_label;
        logic               changed;
    } result_t;

endpackage

[rtl/mrfl_ram.sv]
module mrfl_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[rtl/mrf_icm_voxel_labeler.sv]
// channel  | dir | handshake                  | payload
// voxel    | in  | voxel_valid / voxel_ready  | mrfl_pkg::voxel_t
// result   | out | result_valid / result_ready| mrfl_pkg::result_t
// apb      | in  | psel, penable, pready      | paddr, pwdata, prdata
//
// Five register stages: table read + label sums, score, energy, pair argmax,
// final argmax into the output register. One voxel per cycle while the output is not stalled.
// Table loads write at most one of six per-class RAMs and produce no transfer.
// Each stage holds while its successor is full and stalled; bubbles collapse.
// rst_n clears valid bits and sets the smoothing weight to 4096; the table is not cleared.
module mrf_icm_voxel_labeler #(
    parameter int INTENSITY_LEVELS = mrfl_pkg::INTENSITY_LEVELS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                voxel_valid,
    output logic                                voxel_ready,
    input  mrfl_pkg::voxel_t                    voxel,

    output logic                                result_valid,
    input  logic                                result_ready,
    output mrfl_pkg::result_t                   result,

    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [mrfl_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [mrfl_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [mrfl_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);

    localparam int NC    = mrfl_pkg::NUM_CLASSES;
    localparam int LW    = mrfl_pkg::LABEL_W;
    localparam int COL_W = $clog2(INTENSITY_LEVELS);
    localparam int CMP_W = ((COL_W > mrfl_pkg::INTENSITY_W) ? COL_W : mrfl_pkg::INTENSITY_W) + 1;

    // ---------------- configuration ----------------
    logic [mrfl_pkg::WEIGHT_W-1:0] smoothing_weight_reg;
    logic                          cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr[2] == mrfl_pkg::ADDR_SMOOTHING);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smoothing_weight_reg <= mrfl_pkg::SMOOTHING_RESET;
        end
        else if (cfg_wr)
        begin
            smoothing_weight_reg <= pwdata[mrfl_pkg::WEIGHT_W-1:0];
        end
    end

    assign prdata = (paddr[2] == mrfl_pkg::ADDR_SMOOTHING)
                    ? mrfl_pkg::APB_DATA_W'(smoothing_weight_reg)
                    : '0;

    // ---------------- stage enables ----------------
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic en1, en2, en3, en4, en5;

    assign en5 = !v5_reg || result_ready;
    assign en4 = !v4_reg || en5;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;

    assign voxel_ready  = en1;
    assign result_valid = v5_reg;

    logic accept;
    logic is_classify;

    assign accept      = voxel_valid && voxel_ready;
    assign is_classify = (voxel.operation == mrfl_pkg::OP_CLASSIFY);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= voxel_valid && is_classify;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
            if (en4)
            begin
                v4_reg <= v3_reg;
            end
            if (en5)
            begin
                v5_reg <= v4_reg;
            end
        end
    end

    // ---------------- table addressing ----------------
    logic [CMP_W-1:0] col_ext;
    logic             col_in_range;
    logic [COL_W-1:0] rd_col;

    assign col_ext      = CMP_W'(voxel.intensity);
    assign col_in_range = col_ext < CMP_W'(INTENSITY_LEVELS);
    assign rd_col       = col_in_range ? col_ext[COL_W-1:0] : COL_W'(INTENSITY_LEVELS - 1);

    // ---------------- shared control through the stages ----------------
    logic          zero1_reg, zero2_reg, zero3_reg, zero4_reg;
    logic [LW-1:0] cur1_reg, cur2_reg, cur3_reg, cur4_reg;

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            zero1_reg <= (voxel.intensity == '0);
            cur1_reg  <= voxel.current_label;
        end
        if (en2)
        begin
            zero2_reg <= zero1_reg;
            cur2_reg  <= cur1_reg;
        end
        if (en3)
        begin
            zero3_reg <= zero2_reg;
            cur3_reg  <= cur2_reg;
        end
        if (en4)
        begin
            zero4_reg <= zero3_reg;
            cur4_reg  <= cur3_reg;
        end
    end

    logic signed [mrfl_pkg::ENERGY_W-1:0] energy3_reg [NC];

    // ---------------- per-class lanes: stages 1..3 ----------------
    for (genvar k = 0; k < NC; k++)
    begin : g_class
        logic [mrfl_pkg::LIK_W-1:0]          lik_rd;
        logic                                we;
        logic signed [mrfl_pkg::SUM_W-1:0]   face_sum, edge_lo, edge_hi;
        logic signed [mrfl_pkg::SUM_W-1:0]   face_sum_reg, edge_lo_reg, edge_hi_reg;
        logic signed [mrfl_pkg::SCORE_W-1:0] edge_sum, score;
        logic signed [mrfl_pkg::SCORE_W-1:0] score_reg;
        logic signed [mrfl_pkg::LIK_W-1:0]   lik2_reg;
        logic signed [mrfl_pkg::PROD_W-1:0]  prod;
        logic signed [mrfl_pkg::ENERGY_W-1:0] energy;

        assign we = accept && (voxel.operation == mrfl_pkg::OP_LOAD)
                    && (voxel.class_index == LW'(k)) && col_in_range;

        mrfl_ram #(
            .WIDTH (mrfl_pkg::LIK_W),
            .DEPTH (INTENSITY_LEVELS)
        ) u_ram (
            .clk   (clk),
            .we    (we),
            .waddr (col_ext[COL_W-1:0]),
            .wdata (voxel.likelihood_value),
            .re    (en1),
            .raddr (rd_col),
            .rdata (lik_rd)
        );

        always_comb
        begin
            face_sum = '0;
            edge_lo  = '0;
            edge_hi  = '0;
            for (int i = 0; i < 6; i++)
            begin
                face_sum = face_sum + mrfl_pkg::SUM_W'(
                    mrfl_pkg::CLIQUE_POT[k][voxel.face_labels[LW*i +: LW]]);
                edge_lo  = edge_lo + mrfl_pkg::SUM_W'(
                    mrfl_pkg::CLIQUE_POT[k][voxel.edge_labels[LW*i +: LW]]);
                edge_hi  = edge_hi + mrfl_pkg::SUM_W'(
                    mrfl_pkg::CLIQUE_POT[k][voxel.edge_labels[LW*(i+6) +: LW]]);
            end
        end

        always_ff @(posedge clk)
        begin
            if (en1)
            begin
                face_sum_reg <= face_sum;
                edge_lo_reg  <= edge_lo;
                edge_hi_reg  <= edge_hi;
            end
        end

        // stage 2: Q.7 score
        assign edge_sum = mrfl_pkg::SCORE_W'(edge_lo_reg) + mrfl_pkg::SCORE_W'(edge_hi_reg);
        assign score    = (mrfl_pkg::SCORE_W'(face_sum_reg) <<< 7)
                          + mrfl_pkg::SCORE_W'(edge_sum * mrfl_pkg::SQRT2_Q7);

        always_ff @(posedge clk)
        begin
            if (en2)
            begin
                score_reg <= score;
                lik2_reg  <= $signed(lik_rd);
            end
        end

        // stage 3: Q.19 energy
        assign prod   = $signed({1'b0, smoothing_weight_reg}) * score_reg;
        assign energy = (mrfl_pkg::ENERGY_W'(lik2_reg) <<< mrfl_pkg::LIK_SHIFT)
                        + mrfl_pkg::ENERGY_W'(prod);

        always_ff @(posedge clk)
        begin
            if (en3)
            begin
                energy3_reg[k] <= energy;
            end
        end
    end

    // ---------------- stage 4: pairwise argmax, ties to lower class ----------------
    logic signed [mrfl_pkg::ENERGY_W-1:0] e4_reg   [NC/2];
    logic [LW-1:0]                        idx4_reg [NC/2];

    for (genvar p = 0; p < NC/2; p++)
    begin : g_pair
        logic hi_wins;

        assign hi_wins = energy3_reg[2*p+1] > energy3_reg[2*p];

        always_ff @(posedge clk)
        begin
            if (en4)
            begin
                e4_reg[p]   <= hi_wins ? energy3_reg[2*p+1] : energy3_reg[2*p];
                idx4_reg[p] <= hi_wins ? LW'(2*p+1) : LW'(2*p);
            end
        end
    end

    // ---------------- stage 5: final argmax into output register ----------------
    logic signed [mrfl_pkg::ENERGY_W-1:0] e_ab;
    logic [LW-1:0]                        idx_ab, best, label;
    mrfl_pkg::result_t                    result_next, result_reg;

    always_comb
    begin
        e_ab   = e4_reg[0];
        idx_ab = idx4_reg[0];
        if (e4_reg[1] > e4_reg[0])
        begin
            e_ab   = e4_reg[1];
            idx_ab = idx4_reg[1];
        end
        best  = (e4_reg[2] > e_ab) ? idx4_reg[2] : idx_ab;
        label = best + LW'(1);

        if (zero4_reg)
        begin
            result_next.new_label = '0;
            result_next.changed   = 1'b0;
        end
        else
        begin
            result_next.new_label = label;
            result_next.changed   = (label != cur4_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en5)
        begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

[rtl/mrfl_checker.sv]
module mrfl_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                voxel_valid,
    input logic                                voxel_ready,
    input mrfl_pkg::voxel_t                    voxel,
    input logic                                result_valid,
    input logic                                result_ready,
    input mrfl_pkg::result_t                   result,
    input logic                                psel,
    input logic                                penable,
    input logic                                pwrite,
    input logic [mrfl_pkg::APB_ADDR_W-1:0]     paddr,
    input logic [mrfl_pkg::APB_DATA_W-1:0]     pwdata,
    input logic [mrfl_pkg::APB_DATA_W-1:0]     prdata,
    input logic                                pready
);

    // stalled voxel transfer holds
    a_voxel_hold: assert property (@(posedge clk) disable iff (!rst_n)
        voxel_valid && !voxel_ready |=> voxel_valid && $stable(voxel))
        else $error("voxel changed while stalled");

    // stalled result transfer holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    a_label_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.new_label != 3'd7)
        else $error("label out of range");

    a_background_unchanged: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.new_label == '0 |-> !result.changed)
        else $error("background result flagged changed");

    a_weight_readback: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && pready && !paddr[2]
        |=> paddr[2] || prdata == mrfl_pkg::APB_DATA_W'($past(pwdata[15:0])))
        else $error("smoothing weight readback mismatch");

endmodule

bind mrf_icm_voxel_labeler mrfl_checker u_mrfl_checker (.*);

[tb/sv/tb_mrf_icm_voxel_labeler.sv]
`timescale 1ns / 100ps

module tb_mrf_icm_voxel_labeler;

    localparam int NUM_CLASSES   = mrfl_pkg::NUM_CLASSES;
    localparam int WEIGHT_W      = mrfl_pkg::WEIGHT_W;
    localparam int LABEL_W       = mrfl_pkg::LABEL_W;
    localparam int LIK_W         = mrfl_pkg::LIK_W;
    localparam int APB_ADDR_W    = mrfl_pkg::APB_ADDR_W;
    localparam int APB_DATA_W    = mrfl_pkg::APB_DATA_W;
    localparam int LEVELS        = mrfl_pkg::INTENSITY_LEVELS_DEF;
    localparam int PIPE_LATENCY  = 5;
    localparam int SETTLE_CYCLES = PIPE_LATENCY + 3;
    localparam int CYCLE_LIMIT   = 300000;
    localparam int PHASE_VOXELS  = 80;
    localparam int NUM_PHASES    = 5;
    localparam logic [WEIGHT_W-1:0]   LAMBDA_AT_RESET = 16'd4096;
    localparam logic [APB_ADDR_W-1:0] SMOOTHING_ADDR  = {mrfl_pkg::ADDR_SMOOTHING, 2'b00};

    typedef enum logic [1:0] {RX_ALWAYS, RX_RANDOM, RX_PATTERN, RX_HEAVY} rx_mode_e;
    typedef enum logic [1:0] {NB_RANDOM, NB_UNIFORM, NB_MOSTLY} nb_style_e;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  voxel_valid = 1'b0;
    logic                  voxel_ready;
    mrfl_pkg::voxel_t      voxel = '0;
    logic                  result_valid;
    logic                  result_ready = 1'b0;
    mrfl_pkg::result_t     result;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // clique potential, row = class, column = neighbor label
    int clique_v [NUM_CLASSES][8] = '{
        '{0,  2, -1, -1,  1, -1,  1, 0},
        '{0, -1,  2, -1,  1,  1, -1, 0},
        '{0, -1, -1,  2, -1,  1, -1, 0},
        '{0,  1,  1, -1,  2,  1,  1, 0},
        '{0, -1,  1,  1,  1,  2, -1, 0},
        '{0,  1, -1, -1,  1, -1,  2, 0}
    };

    logic signed [LIK_W-1:0] lik_rows [NUM_CLASSES][LEVELS];
    bit                      lik_loaded [NUM_CLASSES][LEVELS];
    logic [WEIGHT_W-1:0]     lambda_q412 = LAMBDA_AT_RESET;

    mrfl_pkg::result_t labels_in_flight [$];
    mrfl_pkg::result_t due_result;
    int       col_pool [$];
    bit       col_in_pool [LEVELS];
    int       mismatch_count = 0;
    int       cycle_count = 0;
    int       voxels_sent = 0;
    int       burst_left = 0;
    bit       gaps_on = 1'b1;
    rx_mode_e rx_mode = RX_RANDOM;
    int       rx_tick = 0;

    mrf_icm_voxel_labeler u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .voxel_valid  (voxel_valid),
        .voxel_ready  (voxel_ready),
        .voxel        (voxel),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("mrf_icm_voxel_labeler test failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        rx_tick <= rx_tick + 1;
        case (rx_mode)
            RX_ALWAYS:  result_ready <= 1'b1;
            RX_RANDOM:  result_ready <= ($urandom_range(0, 3) != 0);
            RX_PATTERN: result_ready <= ((rx_tick % 7) < 4);
            default:    result_ready <= ($urandom_range(0, 9) < 4);
        endcase
    end

    function automatic void flag_mismatch(input string what, input logic [31:0] exp_v,
                                          input logic [31:0] act_v);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("MISMATCH %s: expected %0h, got %0h at cycle %0d",
                     what, exp_v, act_v, cycle_count);
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            if (labels_in_flight.size() == 0)
                flag_mismatch("transfer with no label due", 32'd0, 32'(result));
            else
            begin
                due_result = labels_in_flight.pop_front();
                if (result.new_label !== due_result.new_label)
                    flag_mismatch("new_label", 32'(due_result.new_label),
                                  32'(result.new_label));
                if (result.changed !== due_result.changed)
                    flag_mismatch("changed", 32'(due_result.changed), 32'(result.changed));
            end
        end
    end

    function automatic int clique_sum(input int cls, input logic [35:0] lbls, input int count);
        int s;
        int i;
        s = 0;
        for (i = 0; i < count; i++)
            s += clique_v[cls][lbls[3*i +: 3]];
        return s;
    endfunction

    function automatic mrfl_pkg::result_t icm_best_label(input mrfl_pkg::voxel_t v);
        mrfl_pkg::result_t r;
        int      col;
        int      best;
        int      k;
        longint  score;
        longint  energy;
        longint  best_energy;
        r = '0;
        if (v.intensity != 0)
        begin
            col = (v.intensity < LEVELS) ? int'(v.intensity) : LEVELS - 1;
            best = 0;
            best_energy = 0;
            for (k = 0; k < NUM_CLASSES; k++)
            begin
                score = 128 * clique_sum(k, {18'b0, v.face_labels}, 6)
                      + 181 * clique_sum(k, v.edge_labels, 12);
                energy = longint'(lik_rows[k][col]) * 2048 + longint'(lambda_q412) * score;
                if (k == 0 || energy > best_energy)
                begin
                    best_energy = energy;
                    best = k;
                end
            end
            r.new_label = LABEL_W'(best + 1);
            r.changed   = (r.new_label != v.current_label);
        end
        return r;
    endfunction

    // track the table and queue the label due for each accepted voxel
    function automatic void take_voxel(input mrfl_pkg::voxel_t v);
        if (v.operation == mrfl_pkg::OP_LOAD)
        begin
            if (v.class_index < NUM_CLASSES && v.intensity < LEVELS)
            begin
                lik_rows[v.class_index][v.intensity]   = v.likelihood_value;
                lik_loaded[v.class_index][v.intensity] = 1'b1;
            end
        end
        else
            labels_in_flight.push_back(icm_best_label(v));
    endfunction

    task automatic send_voxel(input mrfl_pkg::voxel_t v);
        voxel       <= v;
        voxel_valid <= 1'b1;
        do @(posedge clk); while (!voxel_ready);
        take_voxel(v);
        voxels_sent++;
        if (gaps_on)
        begin
            if (burst_left > 0)
                burst_left--;
            else
            begin
                voxel_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
                burst_left = $urandom_range(0, 15);
            end
        end
    endtask

    task automatic send_load(input logic [2:0] cls, input logic [7:0] col,
                             input logic [15:0] value);
        mrfl_pkg::voxel_t v;
        v.operation        = mrfl_pkg::OP_LOAD;
        v.intensity        = col;
        v.current_label    = 3'($urandom_range(0, 7));
        v.face_labels      = 18'($urandom);
        v.edge_labels      = {4'($urandom), 32'($urandom)};
        v.class_index      = cls;
        v.likelihood_value = value;
        send_voxel(v);
    endtask

    task automatic send_classify(input logic [7:0] intensity, input logic [2:0] current,
                                 input logic [35:0] faces, input logic [35:0] edges);
        mrfl_pkg::voxel_t v;
        v.operation        = mrfl_pkg::OP_CLASSIFY;
        v.intensity        = intensity;
        v.current_label    = current;
        v.face_labels      = faces[17:0];
        v.edge_labels      = edges;
        v.class_index      = 3'($urandom_range(0, 7));
        v.likelihood_value = 16'($urandom);
        send_voxel(v);
    endtask

    function automatic logic [35:0] neighbor_labels(input int count, input nb_style_e style,
                                                    input logic [2:0] lbl);
        logic [35:0] lbls;
        int          i;
        lbls = '0;
        for (i = 0; i < count; i++)
        begin
            if (style == NB_RANDOM || (style == NB_MOSTLY && $urandom_range(0, 2) == 0))
                lbls[3*i +: 3] = 3'($urandom_range(0, 7));
            else
                lbls[3*i +: 3] = lbl;
        end
        return lbls;
    endfunction

    // stop sending, wait for every label due, then let loads in flight finish
    task automatic settle_block(input int extra);
        voxel_valid <= 1'b0;
        do @(posedge clk); while (labels_in_flight.size() != 0);
        repeat (extra) @(posedge clk);
    endtask

    task automatic write_smoothing(input logic [WEIGHT_W-1:0] weight);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= SMOOTHING_ADDR;
        pwdata  <= {16'($urandom), weight};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        lambda_q412 = weight;
    endtask

    // all six classes must hold an entry at a column before it is classified
    task automatic ensure_column(input int col);
        int k;
        for (k = 0; k < NUM_CLASSES; k++)
            if (!lik_loaded[k][col])
                send_load(3'(k), 8'(col), 16'($urandom));
        if (!col_in_pool[col])
        begin
            col_pool.push_back(col);
            col_in_pool[col] = 1'b1;
        end
    endtask

    task automatic send_random_classify();
        int         col;
        nb_style_e  style;
        logic [2:0] lbl;
        if (col_pool.size() != 0 && $urandom_range(0, 3) != 0)
            col = col_pool[$urandom_range(0, col_pool.size() - 1)];
        else
            col = $urandom_range(1, LEVELS - 1);
        ensure_column(col);
        style = nb_style_e'($urandom_range(0, 2));
        lbl   = 3'($urandom_range(1, 6));
        send_classify(8'(col), 3'($urandom_range(0, 7)),
                      neighbor_labels(6, style, lbl), neighbor_labels(12, style, lbl));
    endtask

    task automatic test_ties_and_background();
        int k;
        for (k = 0; k < NUM_CLASSES; k++)
            send_load(3'(k), 8'd1, 16'sd0);
        // equal energies everywhere: lowest class wins
        send_classify(8'd1, 3'd1, '0, '0);
        send_classify(8'd1, 3'd0, '1, '1);
        // zero intensity is background regardless of neighbors
        send_classify(8'd0, 3'd5, {4'($urandom), 32'($urandom)}, {4'($urandom), 32'($urandom)});
        send_classify(8'd0, 3'd0, '1, '1);
    endtask

    task automatic test_field_extremes();
        int k;
        send_load(3'd0, 8'd255, 16'h8000);
        for (k = 1; k < NUM_CLASSES - 1; k++)
            send_load(3'(k), 8'd255, 16'($urandom));
        send_load(3'd5, 8'd255, 16'h7FFF);
        send_classify(8'd255, 3'd6, '0, '0);
        send_classify(8'd255, 3'd7, neighbor_labels(6, NB_UNIFORM, 3'd1),
                      neighbor_labels(12, NB_UNIFORM, 3'd1));
        send_classify(8'd255, 3'd3, neighbor_labels(6, NB_RANDOM, 3'd0),
                      neighbor_labels(12, NB_RANDOM, 3'd0));
    endtask

    task automatic test_bad_class_load();
        send_load(3'd6, 8'd1, 16'h7FFF);
        send_load(3'd7, 8'd1, 16'h8000);
        send_classify(8'd1, 3'd1, '0, '0);
    endtask

    task automatic test_weight_extremes();
        settle_block(SETTLE_CYCLES);
        write_smoothing(16'd0);
        send_load(3'd2, 8'd1, 16'sd500);
        send_load(3'd4, 8'd1, 16'sd500);
        // likelihood alone decides; tie between two classes
        send_classify(8'd1, 3'd0, neighbor_labels(6, NB_RANDOM, 3'd0),
                      neighbor_labels(12, NB_RANDOM, 3'd0));
        settle_block(SETTLE_CYCLES);
        write_smoothing(16'hFFFF);
        send_classify(8'd1, 3'd4, neighbor_labels(6, NB_UNIFORM, 3'd4),
                      neighbor_labels(12, NB_UNIFORM, 3'd4));
        send_classify(8'd255, 3'd0, '0, neighbor_labels(12, NB_UNIFORM, 3'd2));
        send_classify(8'd255, 3'd2, neighbor_labels(6, NB_UNIFORM, 3'd6), '0);
    endtask

    task automatic test_random_traffic();
        logic [WEIGHT_W-1:0] weights [NUM_PHASES];
        int                  phase;
        int                  start;
        int                  pick;
        bit                  paused;
        weights = '{LAMBDA_AT_RESET, 16'd0, 16'hFFFF, 16'($urandom),
                    16'($urandom_range(1, 4095))};
        for (phase = 0; phase < NUM_PHASES; phase++)
        begin
            settle_block(SETTLE_CYCLES);
            write_smoothing(weights[phase]);
            rx_mode = rx_mode_e'(phase % 4);
            gaps_on = (phase != 0);
            start   = voxels_sent;
            paused  = 1'b0;
            while (voxels_sent - start < PHASE_VOXELS)
            begin
                if (phase == 2 && !paused && voxels_sent - start >= PHASE_VOXELS / 2)
                begin
                    settle_block(0);
                    paused = 1'b1;
                end
                pick = $urandom_range(0, 99);
                if (pick < 12)
                    send_load(3'($urandom_range(0, NUM_CLASSES - 1)),
                              8'($urandom_range(0, LEVELS - 1)), 16'($urandom));
                else if (pick < 16)
                    send_load(3'($urandom_range(NUM_CLASSES, 7)),
                              8'($urandom_range(0, LEVELS - 1)), 16'($urandom));
                else if (pick < 20)
                    send_classify(8'd0, 3'($urandom_range(0, 7)),
                                  {4'($urandom), 32'($urandom)},
                                  {4'($urandom), 32'($urandom)});
                else
                    send_random_classify();
            end
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_ties_and_background();
        test_field_extremes();
        test_bad_class_load();
        test_weight_extremes();
        test_random_traffic();
        settle_block(SETTLE_CYCLES);
        if (mismatch_count == 0 && labels_in_flight.size() == 0)
            $display("mrf_icm_voxel_labeler test passed");
        else
            $display("mrf_icm_voxel_labeler test failed");
        $finish;
    end

endmodule
